### hw/rtl/psp_pkg.sv
// ----------------------------------------------------------------------------
// Pedal sensor poll and scale: shared package
// Commands, register indexes, conversion constants and the fixed-point
// sample-to-percent helpers.
// ----------------------------------------------------------------------------
package psp_pkg;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 8;
    localparam int SAMPLE_W = 12;
    localparam int PCT_W    = 7;
    localparam int CFG_W    = 16;
    localparam int CIDX_W   = 2;
    localparam int MV_W     = 12;

    // Default timer width
    localparam int TIMER_BITS_DEF = 16;

    // Input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_POLL = 2'd1,
        CMD_RESP = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        REG_RESEND_MIN = 2'd0,
        REG_TIMEOUT    = 2'd1,
        REG_SENSOR_ADR = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_idx_t;

    // Register reset values
    localparam logic [CFG_W-1:0]  RESEND_MIN_RST = 16'd10;
    localparam logic [CFG_W-1:0]  TIMEOUT_RST    = 16'd100;
    localparam logic [ADDR_W-1:0] SENSOR_ADR_RST = 8'd1;

    // floor(s * 3300 / 4095) == (s * 845007) >> 20 for every 12-bit sample.
    localparam logic [19:0] MV_RECIP = 20'd845007;
    localparam int          MV_SHIFT = 20;

    // Throttle window, offset and span (span 800 is a shift by three).
    localparam logic [MV_W-1:0] THR_LO  = 12'd1200;
    localparam logic [MV_W-1:0] THR_HI  = 12'd2200;
    localparam logic [MV_W-1:0] THR_OFS = 12'd1300;

    // Brake window and offset; d * 100 / 1650 == (d * 3972) >> 16 for d < 1500.
    localparam logic [MV_W-1:0] BRK_LO    = 12'd1000;
    localparam logic [MV_W-1:0] BRK_HI    = 12'd2700;
    localparam logic [MV_W-1:0] BRK_OFS   = 12'd1200;
    localparam logic [11:0]     BRK_RECIP = 12'd3972;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // Result flags and percentages
    typedef struct packed {
        logic [PCT_W-1:0] brake_percent;
        logic [PCT_W-1:0] throttle_percent;
        logic             link_ok;
        logic             send_request;
    } result_t;

    // Converter code to millivolts
    function automatic logic [MV_W-1:0] to_mv(input logic [SAMPLE_W-1:0] sample);
        logic [31:0] prod;
        prod = 32'(sample) * 32'(MV_RECIP);
        return prod[MV_SHIFT +: MV_W];
    endfunction

    // Throttle millivolts to percent, zero outside the window
    function automatic logic [PCT_W-1:0] thr_pct(input logic [MV_W-1:0] mv);
        logic [MV_W-1:0] diff;
        logic [MV_W-4:0] quo;
        diff = mv - THR_OFS;
        quo  = diff[MV_W-1:3];
        if (mv > THR_LO && mv < THR_HI && mv > THR_OFS) begin
            return (quo > (MV_W-3)'(PCT_MAX)) ? PCT_MAX : quo[PCT_W-1:0];
        end
        return '0;
    endfunction

    // Brake millivolts to percent, zero outside the window
    function automatic logic [PCT_W-1:0] brk_pct(input logic [MV_W-1:0] mv);
        logic [MV_W-1:0] diff;
        logic [23:0]     prod;
        logic [7:0]      quo;
        diff = mv - BRK_OFS;
        prod = 24'(diff) * 24'(BRK_RECIP);
        quo  = prod[23:16];
        if (mv > BRK_LO && mv < BRK_HI && mv > BRK_OFS) begin
            return (quo > 8'(PCT_MAX)) ? PCT_MAX : quo[PCT_W-1:0];
        end
        return '0;
    endfunction

endpackage

### hw/rtl/pedal_sensor_poll_and_scale_top.sv
// ----------------------------------------------------------------------------
// Pedal sensor poll and scale: top level
// Polls a remote pedal board and turns its throttle and brake samples into
// percent positions.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one command per transaction in s_tuser (tick,
//   poll or response); response payload sits in s_tdata. Every input
//   transaction produces exactly one output transaction on the m_ stream,
//   in order.
//   The item is registered on acceptance, with both samples already
//   converted to millivolts by one constant multiply, and the timer, poll
//   and window/scale logic then fill the result register.
//   Throughput is one item per cycle; both stages move together whenever
//   the result register is empty or being drained.
//   When m_tready is low with a result pending, the input stage keeps one
//   more item and then s_tready drops until the receiver takes the result.
//   Configuration writes on cfg_* are taken at any cycle (cfg_ready is
//   always high) and should only be issued while the block is idle.
//   Reset (aresetn low, synchronous) empties both stages, loads the register
//   defaults, clears the timer, miss count and stored positions, and marks
//   the sensor ready.
// ----------------------------------------------------------------------------
module pedal_sensor_poll_and_scale_top #(
    parameter int TIMER_BITS = psp_pkg::TIMER_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // s_tdata: source_address[7:0], throttle_sample[19:8], brake_sample[31:20]
    input  logic [31:0]                s_tdata,
    // s_tuser: command[1:0]
    input  logic [psp_pkg::CMD_W-1:0]  s_tuser,
    // Result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // m_tdata: send_request[0], link_ok[1], throttle_percent[8:2],
    //          brake_percent[15:9]
    output logic [15:0]                m_tdata,
    // Configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [psp_pkg::CIDX_W-1:0] cfg_index,
    input  logic [psp_pkg::CFG_W-1:0]  cfg_data
);
    import psp_pkg::*;

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    // Configuration registers
    logic [CFG_W-1:0]  resend_min_reg;
    logic [CFG_W-1:0]  timeout_reg;
    logic [ADDR_W-1:0] sensor_adr_reg;

    // Input stage
    logic              in_valid_reg;
    cmd_t              in_cmd_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [MV_W-1:0]   in_thr_mv_reg;
    logic [MV_W-1:0]   in_brk_mv_reg;

    // Block state
    logic [TIMER_BITS-1:0] wait_timer_reg, wait_timer_next;
    logic                  ready_reg, ready_next;
    logic [1:0]            miss_count_reg, miss_count_next;
    logic [PCT_W-1:0]      thr_store_reg, thr_store_next;
    logic [PCT_W-1:0]      brk_store_reg, brk_store_next;

    // Result stage
    logic    out_valid_reg;
    result_t res_reg, res_next;

    logic out_free;
    logic advance;
    logic s_accept;

    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

    // Configuration writes; an index beyond the list is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resend_min_reg <= RESEND_MIN_RST;
            timeout_reg    <= TIMEOUT_RST;
            sensor_adr_reg <= SENSOR_ADR_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_idx_t'(cfg_index))
                REG_RESEND_MIN: resend_min_reg <= cfg_data;
                REG_TIMEOUT:    timeout_reg    <= cfg_data;
                REG_SENSOR_ADR: sensor_adr_reg <= cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // Input stage: register the command and the samples in millivolts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cmd_reg    <= cmd_t'(s_tuser);
            in_addr_reg   <= s_tdata[7:0];
            in_thr_mv_reg <= to_mv(s_tdata[19:8]);
            in_brk_mv_reg <= to_mv(s_tdata[31:20]);
        end
    end

    // Timer, poll decision, response handling and scaling
    always_comb begin
        logic             due;
        logic             suppress;
        logic [1:0]       miss_inc;
        logic [CMP_W-1:0] timer_ext;

        wait_timer_next = wait_timer_reg;
        ready_next      = ready_reg;
        miss_count_next = miss_count_reg;
        thr_store_next  = thr_store_reg;
        brk_store_next  = brk_store_reg;
        res_next        = '0;

        timer_ext = CMP_W'(wait_timer_reg);
        due       = (timer_ext > CMP_W'(resend_min_reg) && ready_reg) ||
                    (timer_ext > CMP_W'(timeout_reg));
        suppress  = 1'b0;
        miss_inc  = miss_count_reg + 2'd1;

        case (in_cmd_reg)
            CMD_TICK: begin
                if (wait_timer_reg != '1) begin
                    wait_timer_next = wait_timer_reg + TIMER_BITS'(1);
                end
            end
            CMD_POLL: begin
                if (due) begin
                    if (!ready_reg) begin
                        // Second miss in a row: hold off and report failure.
                        if (miss_inc > 2'd1) begin
                            miss_count_next = '0;
                            suppress        = 1'b1;
                        end else begin
                            miss_count_next = miss_inc;
                        end
                    end else begin
                        ready_next      = 1'b0;
                        miss_count_next = '0;
                    end
                    if (!suppress) begin
                        wait_timer_next       = '0;
                        res_next.send_request = 1'b1;
                    end
                end
                res_next.link_ok = !suppress;
            end
            CMD_RESP: begin
                if (in_addr_reg == sensor_adr_reg) begin
                    thr_store_next   = thr_pct(in_thr_mv_reg);
                    brk_store_next   = brk_pct(in_brk_mv_reg);
                    ready_next       = 1'b1;
                    wait_timer_next  = '0;
                    res_next.link_ok = 1'b1;
                end
            end
            default: ;
        endcase

        res_next.throttle_percent = thr_store_next;
        res_next.brake_percent    = brk_store_next;
    end

    // State and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_timer_reg <= '0;
            ready_reg      <= 1'b1;
            miss_count_reg <= '0;
            thr_store_reg  <= '0;
            brk_store_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (advance) begin
                wait_timer_reg <= wait_timer_next;
                ready_reg      <= ready_next;
                miss_count_reg <= miss_count_next;
                thr_store_reg  <= thr_store_next;
                brk_store_reg  <= brk_store_next;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    // A sent request always reports a good link.
    a_send_ok : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!res_reg.send_request || res_reg.link_ok))
        else $error("send_request without link_ok");

    // Stored positions never exceed full scale.
    a_pct_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (thr_store_reg <= PCT_MAX) && (brk_store_reg <= PCT_MAX))
        else $error("stored position above full scale");

    // A sent request clears the timer and waits for a response.
    a_send_state : assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_next.send_request) |=> (wait_timer_reg == '0 && !ready_reg))
        else $error("request sent without timer clear or ready drop");

    // The miss counter wraps back before it can reach two.
    a_miss_range : assert property (@(posedge aclk) disable iff (!aresetn)
        miss_count_reg <= 2'd1)
        else $error("miss count out of range");

endmodule
